/* design/vpve_pkg.sv */
// Package with the shared types, codes and constants of the voice effect unit.
package vpve_pkg;

  // Number of voices held in the voice file.
  localparam int VOICES = 4;

  // Field widths of the command and result items.
  localparam int OpW     = 2;
  localparam int SelW    = 2;
  localparam int PeriodW = 16;
  localparam int KindW   = 4;
  localparam int StepW   = 8;
  localparam int VolInW  = 8;
  localparam int VolW    = 7;

  // Period and volume limits.
  localparam logic [PeriodW-1:0] PeriodMin = 16'h0071;
  localparam logic [PeriodW-1:0] PeriodMax = 16'h0357;
  localparam logic [VolW-1:0]    VolumeMax = 7'h40;

  // Command codes.
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_PERIOD = 2'd2,
    OP_VOLUME = 2'd3
  } op_e;

  // Effect kinds; every kind here but KindNone does something on a tick.
  localparam logic [KindW-1:0] KindNone      = 4'd0;
  localparam logic [KindW-1:0] KindSlideDown = 4'd1;
  localparam logic [KindW-1:0] KindSlideUp   = 4'd2;
  localparam logic [KindW-1:0] KindPorta     = 4'd3;
  localparam logic [KindW-1:0] KindVolA      = 4'd5;
  localparam logic [KindW-1:0] KindVolB      = 4'd6;
  localparam logic [KindW-1:0] KindVolC      = 4'd10;

  // One accepted command.
  typedef struct packed {
    op_e                opcode;
    logic [SelW-1:0]    voice_sel;
    logic [PeriodW-1:0] target_period;
    logic [KindW-1:0]   effect_kind;
    logic [StepW-1:0]   step_byte;
    logic [PeriodW-1:0] period_in;
    logic [VolInW-1:0]  volume_in;
  } item_t;

  // State of one voice.
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] target;
    logic [KindW-1:0]   kind;
    logic [StepW-1:0]   step;
    logic [VolW-1:0]    volume;
  } voice_t;

  // Write request from the effect logic to the voice file.
  typedef struct packed {
    logic            en;
    logic [SelW-1:0] idx;
    voice_t          data;
  } voice_wr_t;

endpackage

/* design/vpve_voice_file.sv */
// Register file that holds the state of every voice.
module vpve_voice_file
  import vpve_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  voice_wr_t       wr_i,
  input  logic [SelW-1:0] rd_idx_i,
  output voice_t          rd_data_o
);

  voice_t voice_q [VOICES];

  // Voice entries clear to zero at reset and take one write per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      voice_q[wr_i.idx] <= wr_i.data;
    end
  end

  // The read index is only used when it is in range.
  assign rd_data_o = voice_q[rd_idx_i];

endmodule

/* design/vpve_effect_alu.sv */
// Combinational update of one voice for one command.
module vpve_effect_alu
  import vpve_pkg::*;
(
  input  item_t  item_i,
  input  voice_t voice_i,
  output voice_t voice_o
);

  logic [PeriodW-1:0] step_ext;
  logic [PeriodW-1:0] down_p;
  logic [PeriodW-1:0] down_chk;
  logic [PeriodW-1:0] up_p;
  logic [PeriodW-1:0] up_chk;
  logic [PeriodW-1:0] porta_diff;
  logic               porta_hit;
  logic               vol_down;
  logic [VolW:0]      vol_sum;
  logic [VolW-1:0]    vol_tick;

  // Sign-extended step and the period candidates of the slide effects.
  always_comb begin
    step_ext   = {{(PeriodW-StepW){voice_i.step[StepW-1]}}, voice_i.step};
    down_p     = voice_i.period - step_ext;
    down_chk   = down_p - PeriodMin;
    up_p       = voice_i.period + step_ext;
    up_chk     = up_p - PeriodMax;
    porta_diff = up_p - voice_i.target;
    porta_hit  = voice_i.step[StepW-1] ? porta_diff[PeriodW-1] : !porta_diff[PeriodW-1];
  end

  // Volume slide: zero high nibble slides down, otherwise up with a cap.
  // A negative step gives a huge upward step, so the volume goes to the cap.
  always_comb begin
    vol_down = !voice_i.step[StepW-1] && (voice_i.step[StepW-2:4] == '0);
    vol_sum  = {1'b0, voice_i.volume} + {{(VolW-2){1'b0}}, voice_i.step[StepW-2:4]};
    if (vol_down) begin
      if ({3'b0, voice_i.step[3:0]} > voice_i.volume) begin
        vol_tick = '0;
      end else begin
        vol_tick = voice_i.volume - {3'b0, voice_i.step[3:0]};
      end
    end else if (voice_i.step[StepW-1] || (vol_sum > {1'b0, VolumeMax})) begin
      vol_tick = VolumeMax;
    end else begin
      vol_tick = vol_sum[VolW-1:0];
    end
  end

  // Next voice state per command.
  always_comb begin
    voice_o = voice_i;
    case (item_i.opcode)
      OP_TICK: begin
        case (voice_i.kind)
          KindSlideDown: begin
            if (down_chk[PeriodW-1]) begin
              voice_o.period = PeriodMin;
              voice_o.target = '0;
              voice_o.kind   = KindNone;
              voice_o.step   = '0;
            end else begin
              voice_o.period = down_p;
            end
          end
          KindSlideUp: begin
            if (!up_chk[PeriodW-1]) begin
              voice_o.period = PeriodMax;
              voice_o.target = '0;
              voice_o.kind   = KindNone;
              voice_o.step   = '0;
            end else begin
              voice_o.period = up_p;
            end
          end
          KindPorta: begin
            voice_o.period = porta_hit ? voice_i.target : up_p;
          end
          KindVolA, KindVolB, KindVolC: begin
            voice_o.volume = vol_tick;
          end
          default: begin
            voice_o = voice_i;
          end
        endcase
      end
      OP_LOAD: begin
        voice_o.target = item_i.target_period;
        voice_o.kind   = item_i.effect_kind;
        voice_o.step   = item_i.step_byte;
      end
      OP_PERIOD: begin
        if (item_i.period_in < PeriodMin) begin
          voice_o.period = PeriodMin;
        end else if (item_i.period_in > PeriodMax) begin
          voice_o.period = PeriodMax;
        end else begin
          voice_o.period = item_i.period_in;
        end
      end
      OP_VOLUME: begin
        if (item_i.volume_in > {1'b0, VolumeMax}) begin
          voice_o.volume = '0;
        end else begin
          voice_o.volume = item_i.volume_in[VolW-1:0];
        end
      end
      default: begin
        voice_o = voice_i;
      end
    endcase
  end

endmodule

/* design/voice_pitch_volume_effects.sv */
// Top level of the four-voice tracker effect unit.
//
//  Channel   Ports                                         Transfer
//  --------  --------------------------------------------  -------------------------
//  command   start, busy, opcode_i, voice_sel_i,           edge with start & !busy
//            target_period_i, effect_kind_i, step_byte_i,
//            period_in_i, volume_in_i
//  result    done_o, period_out_o, volume_out_o,           edge ending the done_o cycle
//            effect_active_o
//
// One command is taken in every cycle; busy stays low.
// A command taken at one edge passes through the command register, then through
// the effect logic into the result register.
// The voice file is written at the same edge as the result register, so a
// command that follows at once sees the updated voice.
// Reset clears all voices and both valid flags; the receiver cannot stall.
module voice_pitch_volume_effects
  import vpve_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OpW-1:0]           opcode_i,
  input  logic [SelW-1:0]          voice_sel_i,
  input  logic [PeriodW-1:0]       target_period_i,
  input  logic [KindW-1:0]         effect_kind_i,
  input  logic signed [StepW-1:0]  step_byte_i,
  input  logic [PeriodW-1:0]       period_in_i,
  input  logic [VolInW-1:0]        volume_in_i,
  output logic                     done_o,
  output logic [PeriodW-1:0]       period_out_o,
  output logic [VolW-1:0]          volume_out_o,
  output logic                     effect_active_o
);

  logic       cmd_valid_q;
  item_t      cmd_q;
  logic       done_q;
  voice_t     res_q;
  logic       hit;
  voice_t     voice_rd;
  voice_t     voice_nx;
  voice_wr_t  wr;

  assign busy = 1'b0;

  // Command register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= start && !busy;
    end
  end

  // Command register payload.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q.opcode        <= op_e'(opcode_i);
      cmd_q.voice_sel     <= voice_sel_i;
      cmd_q.target_period <= target_period_i;
      cmd_q.effect_kind   <= effect_kind_i;
      cmd_q.step_byte     <= step_byte_i;
      cmd_q.period_in     <= period_in_i;
      cmd_q.volume_in     <= volume_in_i;
    end
  end

  // A voice number beyond the file leaves state alone and reports zeros.
  assign hit = (int'(cmd_q.voice_sel) < VOICES);

  vpve_voice_file u_voice_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_idx_i  (cmd_q.voice_sel),
    .rd_data_o (voice_rd)
  );

  vpve_effect_alu u_effect_alu (
    .item_i  (cmd_q),
    .voice_i (voice_rd),
    .voice_o (voice_nx)
  );

  // Write back the updated voice.
  always_comb begin
    wr.en   = cmd_valid_q && hit;
    wr.idx  = cmd_q.voice_sel;
    wr.data = voice_nx;
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_valid_q;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_valid_q) begin
      res_q <= hit ? voice_nx : '0;
    end
  end

  assign done_o          = done_q;
  assign period_out_o    = res_q.period;
  assign volume_out_o    = res_q.volume;
  assign effect_active_o = (res_q.kind != KindNone);

endmodule

/* design/vpve_checker.sv */
// Port-level checker for the voice effect unit, with its bind.
module vpve_checker
  import vpve_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [OpW-1:0]     opcode_i,
  input logic [VolInW-1:0]  volume_in_i,
  input logic               done_o,
  input logic [PeriodW-1:0] period_out_o,
  input logic [VolW-1:0]    volume_out_o
);

  // Every command transfer gives a result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("command transfer without a result");

  // No result appears without an earlier command transfer.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a command transfer");

  // Reported volume never exceeds the cap.
  a_volume_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (volume_out_o <= VolumeMax))
    else $error("volume above cap");

  // A set period command reports a clamped period.
  a_period_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_PERIOD)) |-> ##2
      ((period_out_o >= PeriodMin) && (period_out_o <= PeriodMax)))
    else $error("set period not clamped");

  // A set volume above the cap stores zero.
  a_volume_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_VOLUME) && (volume_in_i > {1'b0, VolumeMax}))
      |-> ##2 (volume_out_o == '0))
    else $error("oversized volume not zeroed");

endmodule

bind voice_pitch_volume_effects vpve_checker u_vpve_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .opcode_i     (opcode_i),
  .volume_in_i  (volume_in_i),
  .done_o       (done_o),
  .period_out_o (period_out_o),
  .volume_out_o (volume_out_o)
);
